### sv/pgb_pkg.sv
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared sizes, codes, types and helper functions of the particle grid binner.
// ----------------------------------------------------------------------------
`default_nettype none

package pgb_pkg;

    // Grid and coordinate sizes
    localparam int ROWS       = 9;
    localparam int COLS       = 16;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = COORD_BITS - 2;

    // Offset sum, product with cells_per_unit, integer part of the product
    localparam int CPU_W  = 8;
    localparam int SUM_W  = COORD_BITS + 1;
    localparam int PROD_W = SUM_W + CPU_W + 1;
    localparam int IDX_W  = PROD_W - FRAC_BITS;

    // Field widths of items
    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;
    localparam int LEVELS_W = 5;
    localparam int BRIGHT_W = 8;

    // Count store
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = 4;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Brightness scaling: count*255 times a rounded-up reciprocal of the cap
    localparam int NUM_W       = CNT_W + 8;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int SCALED_W    = NUM_W + RECIP_W;

    // Port widths
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET       = 2'd0,
        REG_Y_OFFSET       = 2'd1,
        REG_CELLS_PER_UNIT = 2'd2,
        REG_LEVELS         = 2'd3
    } cfg_reg_t;

    // Request kinds carried on tuser
    typedef enum logic {
        REQ_PARTICLE = 1'b0,
        REQ_READOUT  = 1'b1
    } req_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_INC_RD,
        B_INC_WR,
        B_RO_RD,
        B_RO_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_offset;
        logic signed [COORD_BITS-1:0] y_offset;
        logic [CPU_W-1:0]             cells_per_unit;
        logic [LEVELS_W-1:0]          levels;
    } cfg_t;

    // One queued command: increment a cell, or read out a row from column 0
    typedef struct packed {
        req_t             kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cmd_t;

    // Saturation cap: levels clamped to 2..16, minus one
    function automatic logic [CNT_W-1:0] level_cap(input logic [LEVELS_W-1:0] lv);
        logic [LEVELS_W-1:0] lm;
        lm = lv - LEVELS_W'(1);
        if (lv < LEVELS_W'(2)) begin
            return CNT_W'(1);
        end else if (lv > LEVELS_W'(16)) begin
            return CNT_W'(15);
        end
        return lm[CNT_W-1:0];
    endfunction

    // ceil(2^20 / d); exact quotient for numerators below 2^12
    function automatic logic [RECIP_W-1:0] pgb_recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd1:    r = 21'd1048576;
            4'd2:    r = 21'd524288;
            4'd3:    r = 21'd349526;
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209716;
            4'd6:    r = 21'd174763;
            4'd7:    r = 21'd149797;
            4'd8:    r = 21'd131072;
            4'd9:    r = 21'd116509;
            4'd10:   r = 21'd104858;
            4'd11:   r = 21'd95326;
            4'd12:   r = 21'd87382;
            4'd13:   r = 21'd80660;
            4'd14:   r = 21'd74899;
            4'd15:   r = 21'd69906;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Flat store address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

### sv/particle_grid_binning.sv
// Flow: an item is offset, then scaled, in registered stages, enters the queue, and the back end
//   pops it when idle; a particle's cell is then read from the store and its count written back.
// Back end: a particle takes a pop, a store read and a store write before the next pop;
//   a row readout takes the pop, then one store read and one item per column, waiting on output stalls.
// Reset (aresetn low, synchronous) restores the register defaults, empties the pipeline
//   and queue and marks every cell as zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// particle_grid_binning
// Bins 2-D particle positions into a grid of saturating counts and reads a
// row out as brightness values, clearing it.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_grid_binning import pgb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // [15:0] x_pos, [31:16] y_pos, [35:32] row_sel
    input  wire logic                  s_tuser,  // [0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // [3:0] out_row, [7:4] out_col, [15:8] brightness
    output logic                       m_tlast,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_ready, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_OFFSET:       cfg_next.x_offset       = cfg_data;
                REG_Y_OFFSET:       cfg_next.y_offset       = cfg_data;
                REG_CELLS_PER_UNIT: cfg_next.cells_per_unit = cfg_data[CPU_W-1:0];
                REG_LEVELS:         cfg_next.levels         = cfg_data[LEVELS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_offset       <= 16'sd13107;
            cfg_reg.y_offset       <= '0;
            cfg_reg.cells_per_unit <= CPU_W'(10);
            cfg_reg.levels         <= LEVELS_W'(2);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pgb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_type    (req_t'(s_tuser)),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_row_sel (s_tdata[2*COORD_BITS +: ROW_W]),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_ready    (q_ready)
    );

    pgb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    pgb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### sv/pgb_ram.sv
// ----------------------------------------------------------------------------
// pgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pgb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 144
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/pgb_front.sv
// ----------------------------------------------------------------------------
// pgb_front
// Accepts request items, offsets and scales coordinates, classifies each
// item and pushes in-grid increments and valid row readouts to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pgb_front import pgb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cfg_t                  cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire req_t                  in_type,
    input  wire logic [COORD_BITS-1:0] in_x,
    input  wire logic [COORD_BITS-1:0] in_y,
    input  wire logic [ROW_W-1:0]      in_row_sel,
    output logic                       q_push,
    output cmd_t                       q_cmd,
    input  wire logic                  q_ready
);

    logic                     s1_valid_reg, s1_valid_next;
    req_t                     s1_type_reg;
    logic [ROW_W-1:0]         s1_row_sel_reg;
    logic signed [SUM_W-1:0]  s1_xsum_reg, s1_ysum_reg;

    logic                     s2_valid_reg, s2_valid_next;
    req_t                     s2_type_reg;
    logic [ROW_W-1:0]         s2_row_sel_reg;
    logic signed [PROD_W-1:0] s2_xprod_reg, s2_yprod_reg;

    logic                     x_in, y_in, need_push, s2_free, s1_free;
    logic signed [CPU_W:0]    cpu_s;

    assign cpu_s = $signed({1'b0, cfg.cells_per_unit});

    // Classify the scaled item
    always_comb begin
        x_in = !s2_xprod_reg[PROD_W-1] &&
               (s2_xprod_reg[PROD_W-1:FRAC_BITS] < IDX_W'(COLS));
        y_in = !s2_yprod_reg[PROD_W-1] &&
               (s2_yprod_reg[PROD_W-1:FRAC_BITS] < IDX_W'(ROWS));
        if (s2_type_reg == REQ_READOUT) begin
            need_push = int'(s2_row_sel_reg) < ROWS;
        end else begin
            need_push = x_in && y_in;
        end
        q_cmd.kind = s2_type_reg;
        if (s2_type_reg == REQ_READOUT) begin
            q_cmd.row = s2_row_sel_reg;
            q_cmd.col = '0;
        end else begin
            q_cmd.row = s2_yprod_reg[FRAC_BITS +: ROW_W];
            q_cmd.col = s2_xprod_reg[FRAC_BITS +: COL_W];
        end
    end

    // Stage handshakes: drop items that need no push
    assign q_push        = s2_valid_reg && need_push && q_ready;
    assign s2_free       = !s2_valid_reg || !need_push || q_ready;
    assign s1_free       = !s1_valid_reg || s2_free;
    assign in_ready      = s1_free;
    assign s1_valid_next = s1_free ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage 1: add offsets
    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_type_reg    <= in_type;
            s1_row_sel_reg <= in_row_sel;
            s1_xsum_reg    <= $signed({in_x[COORD_BITS-1], in_x}) +
                              $signed({cfg.x_offset[COORD_BITS-1], cfg.x_offset});
            s1_ysum_reg    <= $signed({in_y[COORD_BITS-1], in_y}) +
                              $signed({cfg.y_offset[COORD_BITS-1], cfg.y_offset});
        end
    end

    // Stage 2: scale by cells per unit
    always_ff @(posedge aclk) begin
        if (s2_free) begin
            s2_type_reg    <= s1_type_reg;
            s2_row_sel_reg <= s1_row_sel_reg;
            s2_xprod_reg   <= s1_xsum_reg * cpu_s;
            s2_yprod_reg   <= s1_ysum_reg * cpu_s;
        end
    end

endmodule

`default_nettype wire

### sv/pgb_queue.sv
// ----------------------------------------------------------------------------
// pgb_queue
// Small command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pgb_queue import pgb_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    assign push_ready = count_reg != Q_CNT_W'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/pgb_back.sv
// ----------------------------------------------------------------------------
// pgb_back
// Executes queued commands on the count store: read-modify-write increments
// and row readouts that emit scaled brightness items and clear the row.
// ----------------------------------------------------------------------------
`default_nettype none

module pgb_back import pgb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 q_valid,
    input  wire cmd_t                 q_cmd,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CELLS-1:0]     vld_reg, vld_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]     m_row_reg, m_row_next;
    logic [COL_W-1:0]     m_col_reg, m_col_next;
    logic [BRIGHT_W-1:0]  m_bright_reg, m_bright_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_load;

    logic                 ram_we, ram_re;
    logic [CNT_W-1:0]     ram_wdata, ram_rdata;

    logic [CNT_W-1:0]     cap, cnt_raw, cnt_clamp;
    logic [NUM_W-1:0]     num;
    logic [SCALED_W-1:0]  scaled;
    logic                 out_free, at_last_col;

    pgb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Count of the addressed cell, scaled to brightness
    always_comb begin
        cap       = level_cap(cfg.levels);
        cnt_raw   = vld_reg[addr_reg] ? ram_rdata : '0;
        cnt_clamp = (cnt_raw > cap) ? cap : cnt_raw;
        num       = (NUM_W'(cnt_clamp) << 8) - NUM_W'(cnt_clamp);
        scaled    = SCALED_W'(num) * SCALED_W'(pgb_recip(cap));
    end

    assign out_free    = !m_valid_reg || m_tready;
    assign at_last_col = col_reg == COL_W'(COLS - 1);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        vld_next      = vld_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wdata     = cnt_raw + CNT_W'(1);
        m_load        = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_row_next    = cmd_reg.row;
        m_col_next    = col_reg;
        m_bright_next = scaled[RECIP_SHIFT +: BRIGHT_W];
        m_last_next   = at_last_col;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    addr_next  = cell_addr(q_cmd.row, q_cmd.col);
                    col_next   = '0;
                    state_next = (q_cmd.kind == REQ_PARTICLE) ? B_INC_RD : B_RO_RD;
                end
            end
            B_INC_RD: begin
                ram_re     = 1'b1;
                state_next = B_INC_WR;
            end
            B_INC_WR: begin
                // Saturate at the cap; never-written cells count as zero
                if (cnt_raw < cap) begin
                    ram_we             = 1'b1;
                    vld_next[addr_reg] = 1'b1;
                end
                state_next = B_IDLE;
            end
            B_RO_RD: begin
                ram_re     = 1'b1;
                state_next = B_RO_EMIT;
            end
            B_RO_EMIT: begin
                // Emit one cell item and clear the cell
                if (out_free) begin
                    m_load             = 1'b1;
                    m_valid_next       = 1'b1;
                    vld_next[addr_reg] = 1'b0;
                    if (at_last_col) begin
                        state_next = B_IDLE;
                    end else begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        col_next   = col_reg + COL_W'(1);
                        state_next = B_RO_RD;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        addr_reg <= addr_next;
        col_reg  <= col_next;
        if (m_load) begin
            m_row_reg    <= m_row_next;
            m_col_reg    <= m_col_next;
            m_bright_reg <= m_bright_next;
            m_last_reg   <= m_last_next;
        end
    end

    // Output fields: [3:0] out_row, [7:4] out_col, [15:8] brightness
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_bright_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

    a_we_only_in_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == B_INC_WR)
        else $error("store written outside increment write");

    a_last_on_final_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_col_reg == COL_W'(COLS - 1))
        else $error("last flag on a column other than the final one");

    a_emit_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_RO_EMIT |->
            ($past(state_reg) == B_RO_RD || $past(state_reg) == B_RO_EMIT))
        else $error("readout emit without a preceding store read");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives particle and row readout items into the grid binner, mirrors the
// count grid and register settings in a local model, and checks every
// emitted cell against it, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pgb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 25;

    // One emitted cell as the checker sees it
    typedef struct {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [BRIGHT_W-1:0] bright;
        logic                last;
    } cell_result_t;

    // Directed plan: either an item to send or a register to write
    typedef enum logic { PLAN_ITEM, PLAN_REG } plan_kind_t;

    typedef struct {
        plan_kind_t          kind;
        req_t                req;
        logic [15:0]         x;
        logic [15:0]         y;
        logic [ROW_W-1:0]    rs;
        logic                typed;
        logic [BRIGHT_W-1:0] b0;
        logic [BRIGHT_W-1:0] brest;
        cfg_reg_t            creg;
        logic [15:0]         cval;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // [15:0] x_pos, [31:16] y_pos, [35:32] row_sel
    logic                  s_tuser   = 1'b0; // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [3:0] out_row, [7:4] out_col, [15:8] brightness
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the registers and the count grid
    logic signed [15:0]    x_off_m;
    logic signed [15:0]    y_off_m;
    logic [CPU_W-1:0]      cpu_m;
    logic [LEVELS_W-1:0]   levels_m;
    logic [CNT_W-1:0]      grid_count [CELLS];

    cell_result_t          cell_expect_q [$];
    plan_row_t             plan [$];
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    logic                  calm      = 1'b0;
    logic                  hold_req  = 1'b0;
    logic                  hold_done = 1'b0;
    int                    hold_left = 0;

    particle_grid_binning dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Saturation cap from the levels register, clamped to 2..16
    function automatic int sat_cap();
        int lv;
        lv = int'(levels_m);
        if (lv < 2) lv = 2;
        if (lv > 16) lv = 16;
        return lv - 1;
    endfunction

    // Map one coordinate to a cell index; return 0 when it falls off the grid
    function automatic bit axis_cell(input logic signed [15:0] coord,
                                     input logic signed [15:0] off,
                                     input int lim, output int idx);
        int sum;
        int prod;
        sum  = int'(coord) + int'(off);
        prod = sum * int'(cpu_m);
        idx  = 0;
        if (prod < 0) return 1'b0;
        idx = prod >>> FRAC_BITS;
        return idx < lim;
    endfunction

    // Advance the grid model by one accepted item and queue the cells it emits
    task automatic bin_predict(input req_t req, input logic [15:0] x, input logic [15:0] y,
                               input logic [ROW_W-1:0] rs, input logic typed,
                               input logic [BRIGHT_W-1:0] b0,
                               input logic [BRIGHT_W-1:0] brest);
        int           col;
        int           row;
        int           cap;
        int           cnt;
        cell_result_t exp_cell;
        cap = sat_cap();
        if (req == REQ_PARTICLE) begin
            if (axis_cell(x, x_off_m, COLS, col) && axis_cell(y, y_off_m, ROWS, row)) begin
                if (int'(grid_count[row*COLS+col]) < cap)
                    grid_count[row*COLS+col] = grid_count[row*COLS+col] + 1'b1;
            end
        end else if (int'(rs) < ROWS) begin
            for (int c = 0; c < COLS; c++) begin
                cnt = int'(grid_count[int'(rs)*COLS+c]);
                if (cnt > cap) cnt = cap;
                exp_cell.row    = rs;
                exp_cell.col    = COL_W'(c);
                exp_cell.bright = BRIGHT_W'((cnt * 255) / cap);
                if (typed) exp_cell.bright = (c == 0) ? b0 : brest;
                exp_cell.last   = (c == COLS - 1);
                cell_expect_q.push_back(exp_cell);
                grid_count[int'(rs)*COLS+c] = '0;
            end
        end
    endtask

    // Offer one item, idling at random first, and hold it until accepted
    task automatic send_item(input req_t req, input logic [15:0] x, input logic [15:0] y,
                             input logic [ROW_W-1:0] rs, input logic typed,
                             input logic [BRIGHT_W-1:0] b0,
                             input logic [BRIGHT_W-1:0] brest);
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, rs, y, x};
        do @(posedge aclk); while (!s_tready);
        bin_predict(req, x, y, rs, typed, b0, brest);
    endtask

    // Write one register; the block is idle whenever this runs
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_X_OFFSET:       x_off_m  = val;
            REG_Y_OFFSET:       y_off_m  = val;
            REG_CELLS_PER_UNIT: cpu_m    = val[CPU_W-1:0];
            REG_LEVELS:         levels_m = val[LEVELS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Drop valid, wait for every expected cell, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cell_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    // Coordinate that lands inside a chosen cell for the current settings
    function automatic logic [15:0] aim_coord(input int bin_idx, input logic signed [15:0] off);
        int sum;
        if (cpu_m == 0) return 16'($urandom());
        sum = (bin_idx * (1 << FRAC_BITS) + int'($urandom_range((1 << FRAC_BITS) - 1)))
              / int'(cpu_m);
        return 16'(sum - int'(off));
    endfunction

    function automatic plan_row_t part_row(input logic [15:0] x, input logic [15:0] y);
        plan_row_t p;
        p = '{PLAN_ITEM, REQ_PARTICLE, x, y, '0, 1'b0, '0, '0, REG_X_OFFSET, '0};
        return p;
    endfunction

    function automatic plan_row_t read_row(input logic [ROW_W-1:0] rs, input logic typed,
                                           input logic [BRIGHT_W-1:0] b0,
                                           input logic [BRIGHT_W-1:0] brest);
        plan_row_t p;
        p = '{PLAN_ITEM, REQ_READOUT, 16'h5A5A, 16'hA5A5, rs, typed, b0, brest,
              REG_X_OFFSET, '0};
        return p;
    endfunction

    function automatic plan_row_t reg_row(input cfg_reg_t idx, input logic [15:0] val);
        plan_row_t p;
        p = '{PLAN_REG, REQ_PARTICLE, '0, '0, '0, 1'b0, '0, '0, idx, val};
        return p;
    endfunction

    // Receiver: random stalls, one long hold-off, and a calm stretch
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 23);
        end
    end

    // Compare each emitted cell with the oldest expectation
    always @(posedge aclk) begin
        cell_result_t exp_cell;
        if (aresetn && m_tvalid && m_tready) begin
            if (cell_expect_q.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected cell: row %0d col %0d bright %0d last %0b",
                             m_tdata[3:0], m_tdata[7:4], m_tdata[15:8], m_tlast);
            end else begin
                exp_cell = cell_expect_q.pop_front();
                if (m_tdata[3:0] !== exp_cell.row || m_tdata[7:4] !== exp_cell.col ||
                    m_tdata[15:8] !== exp_cell.bright || m_tlast !== exp_cell.last) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("cell mismatch: exp row %0d col %0d bright %0d last %0b, %s",
                                 exp_cell.row, exp_cell.col, exp_cell.bright, exp_cell.last,
                                 $sformatf("got row %0d col %0d bright %0d last %0b",
                                           m_tdata[3:0], m_tdata[7:4], m_tdata[15:8],
                                           m_tlast));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int          pick;
        logic [15:0] xo;
        logic [15:0] yo;
        logic [15:0] cpu_v;
        logic [15:0] lv_v;

        x_off_m  = 16'sd13107;
        y_off_m  = '0;
        cpu_m    = 8'd10;
        levels_m = 5'd2;
        for (int i = 0; i < CELLS; i++) grid_count[i] = '0;

        // Directed: reset state, grid edges, drops, saturation, odd settings
        plan.push_back(read_row(4'd0, 1'b1, 8'd0, 8'd0));
        plan.push_back(part_row(16'hCCCD, 16'h0000));
        plan.push_back(part_row(16'hCCCD, 16'h0000));
        plan.push_back(part_row(16'h8000, 16'h0000));
        plan.push_back(part_row(16'h7FFF, 16'h0000));
        plan.push_back(part_row(16'hCCCC, 16'h0000));
        plan.push_back(part_row(16'hCCCD, 16'hFFFF));
        plan.push_back(part_row(16'hCCCD, 16'h7FFF));
        plan.push_back(part_row(16'd13107, 16'd14745));
        plan.push_back(part_row(16'd13108, 16'd14745));
        plan.push_back(part_row(16'hCCCD, 16'd14746));
        plan.push_back(read_row(4'd9, 1'b0, 8'd0, 8'd0));
        plan.push_back(read_row(4'd15, 1'b0, 8'd0, 8'd0));
        plan.push_back(read_row(4'd0, 1'b1, 8'd255, 8'd0));
        plan.push_back(read_row(4'd8, 1'b0, 8'd0, 8'd0));
        plan.push_back(read_row(4'd0, 1'b1, 8'd0, 8'd0));
        plan.push_back(reg_row(REG_LEVELS, 16'd16));
        plan.push_back(reg_row(REG_CELLS_PER_UNIT, 16'd0));
        plan.push_back(reg_row(REG_X_OFFSET, 16'h8000));
        plan.push_back(reg_row(REG_Y_OFFSET, 16'h7FFF));
        plan.push_back(part_row(16'h8000, 16'h8000));
        plan.push_back(part_row(16'h7FFF, 16'h7FFF));
        plan.push_back(read_row(4'd0, 1'b0, 8'd0, 8'd0));
        plan.push_back(reg_row(REG_LEVELS, 16'd0));
        plan.push_back(reg_row(REG_CELLS_PER_UNIT, 16'd255));
        plan.push_back(reg_row(REG_X_OFFSET, 16'd0));
        plan.push_back(reg_row(REG_Y_OFFSET, 16'd0));
        plan.push_back(part_row(16'd0, 16'd0));
        plan.push_back(part_row(16'd64, 16'd0));
        plan.push_back(part_row(16'd65, 16'd0));
        plan.push_back(reg_row(REG_LEVELS, 16'd31));
        plan.push_back(part_row(16'd0, 16'd0));
        plan.push_back(part_row(16'd0, 16'd0));
        plan.push_back(reg_row(REG_LEVELS, 16'd3));
        plan.push_back(read_row(4'd0, 1'b0, 8'd0, 8'd0));

        // Hold reset, then release
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == PLAN_REG) begin
                settle();
                write_reg(plan[i].creg, plan[i].cval);
            end else begin
                send_item(plan[i].req, plan[i].x, plan[i].y, plan[i].rs,
                          plan[i].typed, plan[i].b0, plan[i].brest);
            end
        end

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            settle();
            xo    = 16'(int'($urandom_range(32767)) - 16384);
            yo    = 16'(int'($urandom_range(32767)) - 16384);
            cpu_v = 16'($urandom_range(8, 255));
            lv_v  = 16'($urandom_range(31));
            if (p == 2) begin
                xo    = 16'h7FFF;
                cpu_v = 16'd255;
                lv_v  = 16'd16;
            end else if (p == 4) begin
                xo    = 16'hC000;
                yo    = 16'h0000;
                cpu_v = 16'd1;
                lv_v  = 16'd1;
            end
            write_reg(REG_X_OFFSET, xo);
            write_reg(REG_Y_OFFSET, yo);
            write_reg(REG_CELLS_PER_UNIT, cpu_v);
            write_reg(REG_LEVELS, lv_v);
            calm <= (p == 1);
            if (p == 3) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    send_item(REQ_PARTICLE,
                              aim_coord($urandom_range(COLS - 1), x_off_m),
                              aim_coord($urandom_range(ROWS - 1), y_off_m),
                              4'($urandom()), 1'b0, '0, '0);
                end else if (pick < 75) begin
                    send_item(REQ_PARTICLE, 16'($urandom()), 16'($urandom()),
                              4'($urandom()), 1'b0, '0, '0);
                end else if (pick < 95) begin
                    send_item(REQ_READOUT, 16'($urandom()), 16'($urandom()),
                              4'($urandom_range(ROWS - 1)), 1'b0, '0, '0);
                end else begin
                    send_item(REQ_READOUT, 16'($urandom()), 16'($urandom()),
                              4'($urandom_range(ROWS, 15)), 1'b0, '0, '0);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && cell_expect_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### particle_grid_binning.f
sv/pgb_pkg.sv
sv/pgb_ram.sv
sv/pgb_front.sv
sv/pgb_queue.sv
sv/pgb_back.sv
sv/particle_grid_binning.sv
tb/testbench.sv
